// ===== hdl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the supply condition trigger.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned THRESH_BITS = 24;
  localparam int unsigned TICK_BITS   = 8;
  localparam int unsigned DWELL_BITS  = 10;
  localparam int unsigned NUM_CHAN    = 4;
  localparam int unsigned NUM_STAGES  = NUM_CHAN - 1;
  localparam int unsigned REG_IDX_BITS = 3;

  // register indexes on the configuration channel
  localparam logic [REG_IDX_BITS-1:0] REG_MONITOR_ENABLE    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_MODES     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COMBINE_OPS       = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SENSITIVITY       = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_VOLTAGE_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_CURRENT_THRESHOLD = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_POWER_THRESHOLD   = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_DVM_THRESHOLD     = 3'd7;

  // per-channel compare modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_BELOW    = 2'd1;
  localparam logic [1:0] MODE_ABOVE    = 2'd2;
  localparam logic [1:0] MODE_NONE_ALT = 2'd3;

  // sensitivity codes
  localparam logic [1:0] SENS_LOW  = 2'd0;
  localparam logic [1:0] SENS_MID  = 2'd1;
  localparam logic [1:0] SENS_HIGH = 2'd2;
  localparam logic [1:0] SENS_ZERO = 2'd3;

  localparam logic [DWELL_BITS-1:0] LIMIT_LOW  = 10'd500;
  localparam logic [DWELL_BITS-1:0] LIMIT_MID  = 10'd250;
  localparam logic [DWELL_BITS-1:0] LIMIT_HIGH = 10'd50;
  localparam logic [DWELL_BITS-1:0] LIMIT_ZERO = 10'd0;

  // largest counter value: grows only below the longest limit
  localparam logic [DWELL_BITS-1:0] DWELL_MAX = 10'd754;

  typedef struct packed {
    logic                                  monitor_enable;
    logic [2*NUM_CHAN-1:0]                 channel_modes;
    logic [NUM_STAGES-1:0]                 combine_ops;
    logic [1:0]                            sensitivity;
    logic [NUM_CHAN-1:0][THRESH_BITS-1:0]  thresholds;
  } sct_cfg_t;

  function automatic logic [DWELL_BITS-1:0] dwell_limit(input logic [1:0] sens);
    logic [DWELL_BITS-1:0] lim;
    unique case (sens)
      SENS_LOW:  lim = LIMIT_LOW;
      SENS_MID:  lim = LIMIT_MID;
      SENS_HIGH: lim = LIMIT_HIGH;
      SENS_ZERO: lim = LIMIT_ZERO;
      default:   lim = LIMIT_ZERO;
    endcase
    return lim;
  endfunction

endpackage

// ===== hdl/sct_if.sv =====
// ----------------------------------------------------------------------------
// sct_if
// Valid/ready channels of the supply condition trigger.
// ----------------------------------------------------------------------------
interface sct_sample_if #(
  parameter int unsigned READING_BITS = 24
);
  logic                    valid;
  logic                    ready;
  logic [7:0]              tick_ms;
  logic                    output_on;
  logic [READING_BITS-1:0] voltage_reading;
  logic [READING_BITS-1:0] current_reading;
  logic [READING_BITS-1:0] power_reading;
  logic [READING_BITS-1:0] dvm_reading;

  modport source (output valid, tick_ms, output_on, voltage_reading, current_reading,
                  power_reading, dvm_reading, input ready);
  modport sink   (input valid, tick_ms, output_on, voltage_reading, current_reading,
                  power_reading, dvm_reading, output ready);
endinterface

interface sct_result_if;
  logic       valid;
  logic       ready;
  logic       action_fire;
  logic       condition_met;
  logic [9:0] dwell_count;

  modport source (output valid, action_fire, condition_met, dwell_count, input ready);
  modport sink   (input valid, action_fire, condition_met, dwell_count, output ready);
endinterface

interface sct_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/sct_cond.sv =====
// ----------------------------------------------------------------------------
// sct_cond
// Per-channel threshold compares chained through AND/OR stages.
// ----------------------------------------------------------------------------
module sct_cond #(
  parameter int unsigned READING_BITS = 24
) (
  input  sct_pkg::sct_cfg_t                           cfg_regs,
  input  logic [sct_pkg::NUM_CHAN-1:0][READING_BITS-1:0] reading,
  output logic                                        cond
);
  import sct_pkg::*;

  localparam int unsigned CMP_BITS = (READING_BITS > THRESH_BITS) ? READING_BITS : THRESH_BITS;

  logic [NUM_CHAN-1:0] flag;

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      logic [1:0]          mode;
      logic [CMP_BITS-1:0] rd;
      logic [CMP_BITS-1:0] thr;
      mode = cfg_regs.channel_modes[2*i +: 2];
      rd   = CMP_BITS'(reading[i]);
      thr  = CMP_BITS'(cfg_regs.thresholds[i]);
      case (mode)
        MODE_BELOW: flag[i] = rd < thr;
        MODE_ABOVE: flag[i] = rd > thr;
        default:    flag[i] = 1'b1;
      endcase
    end
  end

  // chain left to right: stage i joins the running value with channel i+1
  always_comb begin
    logic c;
    c = flag[0];
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (cfg_regs.combine_ops[i]) c = c & flag[i+1];
      else                         c = c | flag[i+1];
    end
    cond = c;
  end

endmodule

// ===== hdl/supply_condition_trigger.sv =====
// ----------------------------------------------------------------------------
// supply_condition_trigger
// Dwell-qualified trigger on power supply readings, one result per tick.
// ----------------------------------------------------------------------------
//   channel | dir | handshake   | payload
//   cfg     | in  | valid/ready | index, data (register write)
//   sample  | in  | valid/ready | tick_ms, output_on, four readings
//   result  | out | valid/ready | action_fire, condition_met, dwell_count
//
// One item per cycle while the result is not stalled; items pass through the input register, then the result register.
// The dwell counter and fired latch update as an item moves into the
// result register, so each item sees the state left by the one before.
// rst clears valids, state and configuration registers; cfg is always ready.
// A stalled result holds both stages; sample stalls only when both are full.
// ----------------------------------------------------------------------------
module supply_condition_trigger #(
  parameter int unsigned READING_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  sct_cfg_if.sink    cfg,
  sct_sample_if.sink sample,
  sct_result_if.source result
);
  import sct_pkg::*;

  sct_cfg_t cfg_regs;

  // input stage
  logic                                  s1_valid;
  logic [TICK_BITS-1:0]                  s1_tick;
  logic                                  s1_on;
  logic [NUM_CHAN-1:0][READING_BITS-1:0] s1_reading;
  logic                                  s1_advance;

  // state
  logic [DWELL_BITS-1:0] dwell_counter;
  logic [DWELL_BITS-1:0] dwell_counter_next;
  logic                  fired_latch;
  logic                  fired_latch_next;

  logic cond;
  logic cond_met;
  logic fire;

  // result stage
  logic                  o_valid;
  logic                  o_fire;
  logic                  o_cond;
  logic [DWELL_BITS-1:0] o_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MONITOR_ENABLE:    cfg_regs.monitor_enable <= cfg.data[0];
        REG_CHANNEL_MODES:     cfg_regs.channel_modes  <= cfg.data[2*NUM_CHAN-1:0];
        REG_COMBINE_OPS:       cfg_regs.combine_ops    <= cfg.data[NUM_STAGES-1:0];
        REG_SENSITIVITY:       cfg_regs.sensitivity    <= cfg.data[1:0];
        REG_VOLTAGE_THRESHOLD: cfg_regs.thresholds[0]  <= cfg.data;
        REG_CURRENT_THRESHOLD: cfg_regs.thresholds[1]  <= cfg.data;
        REG_POWER_THRESHOLD:   cfg_regs.thresholds[2]  <= cfg.data;
        REG_DVM_THRESHOLD:     cfg_regs.thresholds[3]  <= cfg.data;
        default: ;
      endcase
    end
  end

  assign s1_advance   = s1_valid && (!o_valid || result.ready);
  assign sample.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_tick       <= sample.tick_ms;
      s1_on         <= sample.output_on;
      s1_reading[0] <= sample.voltage_reading;
      s1_reading[1] <= sample.current_reading;
      s1_reading[2] <= sample.power_reading;
      s1_reading[3] <= sample.dvm_reading;
    end
  end

  sct_cond #(
    .READING_BITS(READING_BITS)
  ) u_cond (
    .cfg_regs (cfg_regs),
    .reading  (s1_reading),
    .cond     (cond)
  );

  always_comb begin
    dwell_counter_next = dwell_counter;
    fired_latch_next   = fired_latch;
    cond_met           = 1'b0;
    fire               = 1'b0;
    if (!s1_on) begin
      fired_latch_next = 1'b0;
    end else if (!cfg_regs.monitor_enable) begin
      dwell_counter_next = '0;
    end else if (cfg_regs.channel_modes != '0) begin
      cond_met = cond;
      if (cond) begin
        if (!fired_latch) begin
          if (dwell_counter < dwell_limit(cfg_regs.sensitivity)) begin
            dwell_counter_next = dwell_counter + DWELL_BITS'(s1_tick);
          end else begin
            dwell_counter_next = '0;
            fire               = 1'b1;
            fired_latch_next   = 1'b1;
          end
        end
      end else begin
        dwell_counter_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_counter <= '0;
      fired_latch   <= 1'b0;
    end else if (s1_advance) begin
      dwell_counter <= dwell_counter_next;
      fired_latch   <= fired_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!o_valid || result.ready) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      o_fire  <= fire;
      o_cond  <= cond_met;
      o_count <= dwell_counter_next;
    end
  end

  assign result.valid         = o_valid;
  assign result.action_fire   = o_fire;
  assign result.condition_met = o_cond;
  assign result.dwell_count   = o_count;

  // a fire always sets the latch
  a_fire_sets_latch: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && fire) |=> fired_latch)
    else $error("fired latch not set after fire");

  // a fired result reports a met condition and a cleared counter
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.action_fire) |-> (result.condition_met && result.dwell_count == '0))
    else $error("fired result with bad condition or count");

  // counter never passes the longest limit plus one tick
  a_dwell_range: assert property (@(posedge clk) disable iff (rst)
    dwell_counter <= DWELL_MAX)
    else $error("dwell counter out of range");

  // sample stalls only with both stages full and the result stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (s1_valid && o_valid && !result.ready))
    else $error("sample stalled without cause");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the supply condition trigger: directed ticks cover
// the dwell, fire and latch corner cases, then random configurations drive
// mostly condition-holding tick runs with random idling on both channels.
// Every result is checked against a cycle-free model of the trigger.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sct_pkg::*;

  localparam int unsigned RB          = 24;
  localparam int unsigned READING_MAX = 24'hFFFFFF;
  localparam int unsigned LONG_HOLD   = 80;
  localparam logic        OP_OR       = 1'b0;
  localparam logic        OP_AND      = 1'b1;

  typedef struct packed {
    logic [TICK_BITS-1:0]         tick_ms;
    logic                         output_on;
    logic [NUM_CHAN-1:0][RB-1:0]  reading;
  } tick_t;

  typedef struct packed {
    logic                  action_fire;
    logic                  condition_met;
    logic [DWELL_BITS-1:0] dwell_count;
  } trig_result_t;

  logic clk = 1'b0;
  logic rst;

  sct_sample_if #(.READING_BITS(RB)) smp_if ();
  sct_result_if                      res_if ();
  sct_cfg_if                         cfg_if ();

  supply_condition_trigger #(.READING_BITS(RB)) u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .sample (smp_if),
    .result (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_t          ticks_to_send[$];
  trig_result_t   trigger_results_q[$];
  sct_cfg_t       reg_shadow;
  sct_cfg_t       plan_cfg;
  logic [DWELL_BITS-1:0] dwell_acc;
  logic           fired_hold;
  int             n_queued;
  int             n_results;
  int             n_err;
  int             hold_reqs;
  int             hold_served;
  int             send_gap;
  int             recv_stall;
  bit             send_calm;
  bit             recv_calm;
  tick_t          next_tick;
  tick_t          drive_tick;
  trig_result_t   want_res;

  function automatic int pick_idle(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the trigger model by one accepted tick and queue its result.
  function automatic void trigger_step(input tick_t t);
    trig_result_t          r;
    logic [NUM_CHAN-1:0]   hit;
    logic                  c;
    logic [1:0]            m;
    logic [DWELL_BITS-1:0] lim;
    r = '0;
    if (!t.output_on) begin
      fired_hold = 1'b0;
    end else if (!reg_shadow.monitor_enable) begin
      dwell_acc = '0;
    end else if (reg_shadow.channel_modes != '0) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        m = reg_shadow.channel_modes[2*i +: 2];
        case (m)
          MODE_BELOW: hit[i] = t.reading[i] < reg_shadow.thresholds[i];
          MODE_ABOVE: hit[i] = t.reading[i] > reg_shadow.thresholds[i];
          default:    hit[i] = 1'b1;
        endcase
      end
      c = hit[0];
      for (int s = 0; s < NUM_STAGES; s++) begin
        c = (reg_shadow.combine_ops[s] == OP_AND) ? (c & hit[s+1]) : (c | hit[s+1]);
      end
      case (reg_shadow.sensitivity)
        SENS_LOW:  lim = LIMIT_LOW;
        SENS_MID:  lim = LIMIT_MID;
        SENS_HIGH: lim = LIMIT_HIGH;
        default:   lim = LIMIT_ZERO;
      endcase
      r.condition_met = c;
      if (!c) begin
        dwell_acc = '0;
      end else if (!fired_hold) begin
        if (dwell_acc < lim) begin
          dwell_acc = dwell_acc + DWELL_BITS'(t.tick_ms);
        end else begin
          dwell_acc     = '0;
          fired_hold    = 1'b1;
          r.action_fire = 1'b1;
        end
      end
    end
    r.dwell_count = dwell_acc;
    trigger_results_q.push_back(r);
  endfunction

  // Track register writes and accepted ticks in acceptance order.
  always @(posedge clk) begin
    if (rst) begin
      reg_shadow = '0;
      dwell_acc  = '0;
      fired_hold = 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_MONITOR_ENABLE:    reg_shadow.monitor_enable = cfg_if.data[0];
          REG_CHANNEL_MODES:     reg_shadow.channel_modes  = cfg_if.data[2*NUM_CHAN-1:0];
          REG_COMBINE_OPS:       reg_shadow.combine_ops    = cfg_if.data[NUM_STAGES-1:0];
          REG_SENSITIVITY:       reg_shadow.sensitivity    = cfg_if.data[1:0];
          REG_VOLTAGE_THRESHOLD: reg_shadow.thresholds[0]  = cfg_if.data;
          REG_CURRENT_THRESHOLD: reg_shadow.thresholds[1]  = cfg_if.data;
          REG_POWER_THRESHOLD:   reg_shadow.thresholds[2]  = cfg_if.data;
          REG_DVM_THRESHOLD:     reg_shadow.thresholds[3]  = cfg_if.data;
          default: ;
        endcase
      end
      if (smp_if.valid && smp_if.ready) begin
        next_tick.tick_ms    = smp_if.tick_ms;
        next_tick.output_on  = smp_if.output_on;
        next_tick.reading[0] = smp_if.voltage_reading;
        next_tick.reading[1] = smp_if.current_reading;
        next_tick.reading[2] = smp_if.power_reading;
        next_tick.reading[3] = smp_if.dvm_reading;
        trigger_step(next_tick);
      end
    end
  end

  // Tick driver: hold the item until taken, then idle or advance.
  always @(posedge clk) begin
    if (rst) begin
      smp_if.valid <= 1'b0;
      send_gap = 0;
    end else if (!smp_if.valid || smp_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        smp_if.valid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        drive_tick = ticks_to_send.pop_front();
        smp_if.tick_ms         <= drive_tick.tick_ms;
        smp_if.output_on       <= drive_tick.output_on;
        smp_if.voltage_reading <= drive_tick.reading[0];
        smp_if.current_reading <= drive_tick.reading[1];
        smp_if.power_reading   <= drive_tick.reading[2];
        smp_if.dvm_reading     <= drive_tick.reading[3];
        smp_if.valid <= 1'b1;
        send_gap = pick_idle(send_calm);
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus requested long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (hold_served < hold_reqs) begin
        hold_served++;
        recv_stall = LONG_HOLD;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        recv_stall = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      n_results++;
      if (trigger_results_q.size() == 0) begin
        $error("unexpected result: fire %0d cond %0d dwell %0d",
               res_if.action_fire, res_if.condition_met, res_if.dwell_count);
        n_err++;
      end else begin
        want_res = trigger_results_q.pop_front();
        if (res_if.action_fire !== want_res.action_fire) begin
          $error("action_fire: expected %0d, got %0d", want_res.action_fire,
                 res_if.action_fire);
          n_err++;
        end
        if (res_if.condition_met !== want_res.condition_met) begin
          $error("condition_met: expected %0d, got %0d", want_res.condition_met,
                 res_if.condition_met);
          n_err++;
        end
        if (res_if.dwell_count !== want_res.dwell_count) begin
          $error("dwell_count: expected %0d, got %0d", want_res.dwell_count,
                 res_if.dwell_count);
          n_err++;
        end
      end
    end
  end

  task automatic push_tick(input logic [TICK_BITS-1:0] tk, input logic on,
                           input logic [RB-1:0] v, input logic [RB-1:0] a,
                           input logic [RB-1:0] w, input logic [RB-1:0] d);
    tick_t t;
    t.tick_ms    = tk;
    t.output_on  = on;
    t.reading[0] = v;
    t.reading[1] = a;
    t.reading[2] = w;
    t.reading[3] = d;
    ticks_to_send.push_back(t);
    n_queued++;
  endtask

  // Call right after a rising edge; returns on the edge that takes the write.
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [23:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic load_config(input sct_cfg_t c);
    plan_cfg = c;
    write_reg(REG_MONITOR_ENABLE,    24'(c.monitor_enable));
    write_reg(REG_CHANNEL_MODES,     24'(c.channel_modes));
    write_reg(REG_COMBINE_OPS,       24'(c.combine_ops));
    write_reg(REG_SENSITIVITY,       24'(c.sensitivity));
    write_reg(REG_VOLTAGE_THRESHOLD, c.thresholds[0]);
    write_reg(REG_CURRENT_THRESHOLD, c.thresholds[1]);
    write_reg(REG_POWER_THRESHOLD,   c.thresholds[2]);
    write_reg(REG_DVM_THRESHOLD,     c.thresholds[3]);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued tick has produced its result.
  task automatic drain();
    while (n_results < n_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [RB-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return RB'(READING_MAX);
    if (r < 40) return RB'($urandom_range(0, 300));
    return RB'($urandom);
  endfunction

  function automatic sct_cfg_t rand_config();
    sct_cfg_t c;
    c.monitor_enable = ($urandom_range(0, 9) != 0);
    c.channel_modes  = ($urandom_range(0, 9) == 0) ? '0 : (2*NUM_CHAN)'($urandom);
    c.combine_ops    = NUM_STAGES'($urandom);
    c.sensitivity    = 2'($urandom);
    for (int i = 0; i < NUM_CHAN; i++) c.thresholds[i] = pick_threshold();
    return c;
  endfunction

  // Reading that makes the channel compare come out as asked, where possible.
  function automatic logic [RB-1:0] pick_reading(input logic [1:0] mode,
                                                 input logic [RB-1:0] thr,
                                                 input bit want);
    int unsigned t;
    int unsigned near;
    bit          close;
    t     = thr;
    near  = $urandom_range(0, 15);
    close = $urandom_range(0, 1);
    if (mode == MODE_BELOW && want && t != 0)
      return RB'(close ? t - 1 - (near % t) : $urandom_range(0, t - 1));
    if (mode == MODE_BELOW && !want)
      return RB'(close ? ((READING_MAX - t < near) ? READING_MAX : t + near)
                       : $urandom_range(t, READING_MAX));
    if (mode == MODE_ABOVE && want && t != READING_MAX)
      return RB'(close ? t + 1 + (near % (READING_MAX - t)) : $urandom_range(t + 1, READING_MAX));
    if (mode == MODE_ABOVE && !want)
      return RB'(close ? t - (near % (t + 1)) : $urandom_range(0, t));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RB'(READING_MAX);
      default: return RB'($urandom);
    endcase
  endfunction

  task automatic gen_tick();
    logic [RB-1:0]          rd[NUM_CHAN];
    logic [TICK_BITS-1:0]   tk;
    bit                     base;
    bit                     want;
    int unsigned            r;
    base = ($urandom_range(0, 99) < 80);
    for (int i = 0; i < NUM_CHAN; i++) begin
      want  = ($urandom_range(0, 9) == 0) ? !base : base;
      rd[i] = pick_reading(plan_cfg.channel_modes[2*i +: 2], plan_cfg.thresholds[i], want);
      if ($urandom_range(0, 19) == 0) rd[i] = RB'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 70)      tk = TICK_BITS'($urandom_range(0, 60));
    else if (r < 90) tk = TICK_BITS'($urandom);
    else             tk = $urandom_range(0, 1) ? '0 : '1;
    push_tick(tk, ($urandom_range(0, 99) < 93), rd[0], rd[1], rd[2], rd[3]);
  endtask

  initial begin
    sct_cfg_t c;
    rst          = 1'b1;
    n_queued     = 0;
    n_results    = 0;
    n_err        = 0;
    hold_reqs    = 0;
    hold_served  = 0;
    send_calm    = 1'b0;
    recv_calm    = 1'b0;
    plan_cfg     = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: monitoring disabled, then output off.
    push_tick('1, 1'b1, '1, '1, '1, '1);
    push_tick('0, 1'b0, '0, '0, '0, '0);
    drain();

    // Monitoring on but every channel mode none: nothing moves.
    c = '0;
    c.monitor_enable = 1'b1;
    load_config(c);
    push_tick('1, 1'b1, '0, '1, '0, '1);
    push_tick(8'd17, 1'b1, '1, '0, '1, '0);
    drain();

    // Mixed modes, all AND, short dwell: count, fire, latch, clear.
    c.channel_modes = {MODE_NONE, MODE_NONE_ALT, MODE_ABOVE, MODE_BELOW};
    c.combine_ops   = {OP_AND, OP_AND, OP_AND};
    c.sensitivity   = SENS_HIGH;
    c.thresholds[0] = 24'd1000;
    c.thresholds[1] = 24'h800000;
    c.thresholds[2] = '0;
    c.thresholds[3] = '1;
    load_config(c);
    push_tick('1,    1'b1, 24'd0,    '1,          '0, '0);
    push_tick('0,    1'b1, 24'd0,    '1,          '0, '0);
    push_tick(8'd200, 1'b1, 24'd0,   '1,          '0, '0);
    push_tick(8'd10, 1'b1, 24'd1000, '1,          '0, '0);
    push_tick(8'd10, 1'b0, 24'd0,    '1,          '0, '0);
    push_tick(8'd30, 1'b1, 24'd999,  24'h800001,  '1, '1);
    push_tick(8'd30, 1'b1, 24'd999,  24'h800000,  '1, '1);
    drain();

    // Longest dwell with OR chain: drive the counter to its top value.
    c.channel_modes = {MODE_BELOW, MODE_BELOW, MODE_BELOW, MODE_BELOW};
    c.combine_ops   = {OP_OR, OP_OR, OP_OR};
    c.sensitivity   = SENS_LOW;
    for (int i = 0; i < NUM_CHAN; i++) c.thresholds[i] = 24'd100;
    load_config(c);
    push_tick('1,     1'b1, '1, '1, '1, '0);
    push_tick(8'd244, 1'b1, '1, '1, '1, '0);
    push_tick('1,     1'b1, '1, '1, '1, '0);
    push_tick(8'd1,   1'b1, '1, '1, '1, '0);
    push_tick(8'd5,   1'b0, '1, '1, '1, '0);
    push_tick('0,     1'b1, '1, '1, '1, '1);
    drain();

    // Zero dwell fires on the first true tick.
    c.channel_modes = {MODE_ABOVE, MODE_ABOVE, MODE_ABOVE, MODE_ABOVE};
    c.combine_ops   = {OP_AND, OP_OR, OP_AND};
    c.sensitivity   = SENS_ZERO;
    for (int i = 0; i < NUM_CHAN; i++) c.thresholds[i] = '0;
    load_config(c);
    push_tick('0, 1'b1, 24'd1, 24'd1, 24'd1, 24'd1);
    push_tick('0, 1'b1, 24'd0, 24'd0, 24'd1, 24'd1);

    for (int p = 0; p < 14; p++) begin
      drain();
      if (p == 0) begin
        c.monitor_enable = 1'b1;
        c.channel_modes  = '1;
        c.combine_ops    = '1;
        c.sensitivity    = SENS_ZERO;
        for (int i = 0; i < NUM_CHAN; i++) c.thresholds[i] = '1;
      end else begin
        c = rand_config();
      end
      load_config(c);
      send_calm = ($urandom_range(0, 4) == 0);
      recv_calm = ($urandom_range(0, 4) == 0);
      if (p == 3) begin
        // Keep offering ticks while the receiver holds off.
        send_calm = 1'b1;
        hold_reqs++;
      end
      repeat (55) gen_tick();
    end

    while (n_results < n_queued) @(posedge clk);
    repeat (10) @(posedge clk);
    if (trigger_results_q.size() != 0) begin
      $error("%0d results never arrived", trigger_results_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== supply_condition_trigger.f =====
hdl/sct_pkg.sv
hdl/sct_if.sv
hdl/sct_cond.sv
hdl/supply_condition_trigger.sv
dv/tb_top.sv
